// ===== hw/rtl/pcw_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the paging codeword encoder.
// No dependencies; every module of the block refers to this package.
package pcw_pkg;

    localparam int unsigned MAX_TEXT_CHARS = 40;

    localparam logic [31:0] BCH_POLY   = 32'hED20_0000;
    localparam logic [6:0]  EOT_CHAR   = 7'h04;

    localparam int unsigned ADDR_W     = 21;
    localparam int unsigned SLOT_W     = 5;
    localparam int unsigned PAYLOAD_W  = 20;
    localparam int unsigned HEAD_W     = 21;  // codeword bits 31..11
    localparam int unsigned CNT_W      = 5;
    localparam int unsigned TAKEN_W    = 6;

    // register indexes of the configuration channel
    localparam logic [1:0] CFG_PAGER_ADDRESS  = 2'd0;
    localparam logic [1:0] CFG_FUNCTION_BITS  = 2'd1;
    localparam logic [1:0] CFG_INVERT_OUTPUT  = 2'd2;
    localparam logic [1:0] CFG_SECOND_BATCH   = 2'd3;

    localparam logic [1:0] BATCH_MODE_TRUNCATE = 2'd0;

    typedef struct packed {
        logic [ADDR_W-1:0] pager_address;
        logic [1:0]        function_bits;
        logic              invert_output;
        logic [1:0]        second_batch_mode;
    } pcw_cfg_t;

    // one result before the check bits are added
    typedef struct packed {
        logic [HEAD_W-1:0] head;
        logic [SLOT_W-1:0] slot;
        logic              last;
        logic              done;
        logic [1:0]        batches;
    } pcw_entry_t;

    // all results caused by one input word
    typedef struct packed {
        pcw_entry_t [2:0] e;
        logic [1:0]       count;
    } pcw_group_t;

endpackage

// ===== hw/rtl/pcw_cfg_regs.sv =====
`timescale 1ns / 1ps
// Configuration register file of the paging codeword encoder.
// Depends on pcw_pkg.
module pcw_cfg_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [1:0]                    cfg_index,
    input  logic [pcw_pkg::ADDR_W-1:0]    cfg_data,
    output pcw_pkg::pcw_cfg_t             cfg
);

    pcw_pkg::pcw_cfg_t cfg_reg;
    pcw_pkg::pcw_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                pcw_pkg::CFG_PAGER_ADDRESS: cfg_next.pager_address     = cfg_data;
                pcw_pkg::CFG_FUNCTION_BITS: cfg_next.function_bits     = cfg_data[1:0];
                pcw_pkg::CFG_INVERT_OUTPUT: cfg_next.invert_output     = cfg_data[0];
                pcw_pkg::CFG_SECOND_BATCH:  cfg_next.second_batch_mode = cfg_data[1:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pager_address     <= pcw_pkg::ADDR_W'(1);
            cfg_reg.function_bits     <= 2'd0;
            cfg_reg.invert_output     <= 1'b0;
            cfg_reg.second_batch_mode <= 2'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/pcw_packer.sv =====
`timescale 1ns / 1ps
// Message state and bit packer: turns one input word into up to three
// unsealed codeword heads with slots and end-of-message flags. Depends on pcw_pkg.
module pcw_packer
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           char_code,
    input  logic                 has_char,
    input  logic                 end_of_text,
    input  pcw_pkg::pcw_cfg_t    cfg,
    output pcw_pkg::pcw_group_t  group
);

    typedef struct packed {
        logic [pcw_pkg::PAYLOAD_W-1:0] payload;
        logic [pcw_pkg::CNT_W-1:0]     count;
        logic                          full;
        logic [pcw_pkg::PAYLOAD_W-1:0] word;
    } pcw_push_t;

    logic [pcw_pkg::PAYLOAD_W-1:0] payload_reg, payload_next;
    logic [pcw_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [pcw_pkg::SLOT_W-1:0]    slot_reg, slot_next;
    logic [pcw_pkg::TAKEN_W-1:0]   taken_reg, taken_next;
    logic                          in_msg_reg, in_msg_next;

    // first transmitted bit lands highest
    function automatic logic [6:0] reverse7(input logic [6:0] c);
        logic [6:0] r;
        for (int b = 0; b < 7; b++)
            r[6-b] = c[b];
        return r;
    endfunction

    // append seven bits; at most one full payload falls out
    function automatic pcw_push_t push7(input logic [pcw_pkg::PAYLOAD_W-1:0] p,
                                        input logic [pcw_pkg::CNT_W-1:0] cnt,
                                        input logic [6:0] bits);
        pcw_push_t r;
        logic [pcw_pkg::CNT_W-1:0] total;
        logic [26:0] all_bits;
        logic [26:0] shifted;
        logic [2:0]  sh;
        total    = cnt + pcw_pkg::CNT_W'(7);
        all_bits = {p, bits};
        sh       = 3'(total - pcw_pkg::CNT_W'(pcw_pkg::PAYLOAD_W));
        shifted  = all_bits >> sh;
        r.word   = shifted[pcw_pkg::PAYLOAD_W-1:0];
        if (total >= pcw_pkg::CNT_W'(pcw_pkg::PAYLOAD_W))
        begin
            r.full    = 1'b1;
            r.count   = pcw_pkg::CNT_W'(sh);
            r.payload = all_bits[pcw_pkg::PAYLOAD_W-1:0]
                        & ((pcw_pkg::PAYLOAD_W'(1) << sh) - pcw_pkg::PAYLOAD_W'(1));
        end
        else
        begin
            r.full    = 1'b0;
            r.count   = total;
            r.payload = all_bits[pcw_pkg::PAYLOAD_W-1:0];
        end
        return r;
    endfunction

    logic                          active;
    logic                          start;
    logic                          take;
    logic [pcw_pkg::PAYLOAD_W-1:0] base_payload;
    logic [pcw_pkg::CNT_W-1:0]     base_count;
    logic [pcw_pkg::TAKEN_W-1:0]   base_taken;
    logic [pcw_pkg::SLOT_W-1:0]    base_slot;
    pcw_push_t                     push_char, push_eot;
    logic [pcw_pkg::PAYLOAD_W-1:0] p1, p2, aligned;
    logic [pcw_pkg::CNT_W-1:0]     c1, c2;
    logic [3:0]                    cand_valid;
    logic [pcw_pkg::HEAD_W-1:0]    cand_head [4];
    logic [2:0]                    n;
    logic [pcw_pkg::SLOT_W-1:0]    last_slot;
    logic [1:0]                    batches;

    always_comb
    begin
        active       = has_char | end_of_text;
        start        = !in_msg_reg;
        base_payload = start ? '0 : payload_reg;
        base_count   = start ? '0 : count_reg;
        base_taken   = start ? '0 : taken_reg;
        base_slot    = start ? {1'b0, cfg.pager_address[2:0], 1'b0} : slot_reg;
        take         = has_char && (base_taken < pcw_pkg::TAKEN_W'(pcw_pkg::MAX_TEXT_CHARS));

        push_char = push7(base_payload, base_count, reverse7(char_code[6:0]));
        p1 = take ? push_char.payload : base_payload;
        c1 = take ? push_char.count   : base_count;

        push_eot = push7(p1, c1, reverse7(pcw_pkg::EOT_CHAR));
        p2 = end_of_text ? push_eot.payload : p1;
        c2 = end_of_text ? push_eot.count   : c1;

        aligned = p2 << (pcw_pkg::CNT_W'(pcw_pkg::PAYLOAD_W) - c2);

        // address word, char overflow, EOT overflow, final partial word
        cand_valid[0] = active && start;
        cand_head[0]  = {1'b0, cfg.pager_address[pcw_pkg::ADDR_W-1:3], cfg.function_bits};
        cand_valid[1] = active && take && push_char.full;
        cand_head[1]  = {1'b1, push_char.word};
        cand_valid[2] = end_of_text && push_eot.full;
        cand_head[2]  = {1'b1, push_eot.word};
        cand_valid[3] = end_of_text && (c2 != '0);
        cand_head[3]  = {1'b1, aligned};

        n     = '0;
        group = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (cand_valid[i] && n < 3'd3)
            begin
                group.e[n[1:0]].head = cand_head[i];
                group.e[n[1:0]].slot = base_slot + pcw_pkg::SLOT_W'(n);
                n = n + 3'd1;
            end
        end
        group.count = n[1:0];

        last_slot = base_slot + pcw_pkg::SLOT_W'(n) - pcw_pkg::SLOT_W'(1);
        batches   = (!last_slot[pcw_pkg::SLOT_W-1]
                     && cfg.second_batch_mode == pcw_pkg::BATCH_MODE_TRUNCATE) ? 2'd1 : 2'd2;
        for (int k = 0; k < 3; k++)
        begin
            if (n != '0 && 3'(k) == n - 3'd1)
            begin
                group.e[k].last    = 1'b1;
                group.e[k].done    = end_of_text;
                group.e[k].batches = end_of_text ? batches : 2'd0;
            end
        end

        payload_next = payload_reg;
        count_next   = count_reg;
        slot_next    = slot_reg;
        taken_next   = taken_reg;
        in_msg_next  = in_msg_reg;
        if (accept && active)
        begin
            if (end_of_text)
            begin
                payload_next = '0;
                count_next   = '0;
                slot_next    = '0;
                taken_next   = '0;
                in_msg_next  = 1'b0;
            end
            else
            begin
                payload_next = p2;
                count_next   = c2;
                slot_next    = base_slot + pcw_pkg::SLOT_W'(n);
                taken_next   = base_taken + pcw_pkg::TAKEN_W'(take);
                in_msg_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            payload_reg <= '0;
            count_reg   <= '0;
            slot_reg    <= '0;
            taken_reg   <= '0;
            in_msg_reg  <= 1'b0;
        end
        else
        begin
            payload_reg <= payload_next;
            count_reg   <= count_next;
            slot_reg    <= slot_next;
            taken_reg   <= taken_next;
            in_msg_reg  <= in_msg_next;
        end
    end

endmodule

// ===== hw/rtl/pcw_result_queue.sv =====
`timescale 1ns / 1ps
// Three-entry result buffer, BCH(31,21)/parity sealing and output register.
// Depends on pcw_pkg.
module pcw_result_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  pcw_pkg::pcw_group_t  group,
    input  logic                 invert,
    output logic                 can_load,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [39:0]          m_tdata,   // codeword[31:0], slot_index[36:32], zero pad
    output logic                 m_tlast,   // last_of_run
    output logic [2:0]           m_tuser    // message_done[0], batch_count[2:1]
);

    // check-bit column for head bit k (codeword bit 11+k), folded at elaboration
    function automatic logic [10:0] bch_col(input int k);
        logic [31:0] r;
        r = 32'h1 << (11 + k);
        for (int i = 0; i < 21; i++)
        begin
            if (r[31])
                r = r ^ pcw_pkg::BCH_POLY;
            r = r << 1;
        end
        return r[31:21];
    endfunction

    function automatic logic [31:0] seal(input logic [pcw_pkg::HEAD_W-1:0] head);
        logic [10:0] chk;
        logic [31:0] w;
        chk = '0;
        for (int k = 0; k < pcw_pkg::HEAD_W; k++)
        begin
            if (head[k])
                chk = chk ^ bch_col(k);
        end
        w = {head, chk};
        return {w[31:1], w[0] | (^w)};
    endfunction

    pcw_pkg::pcw_entry_t [2:0] buf_reg, buf_next;
    logic [1:0]                cnt_reg, cnt_next;
    logic                      valid_reg, valid_next;
    logic [31:0]               word_reg, word_next;
    logic [pcw_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic                      last_reg, last_next;
    logic                      done_reg, done_next;
    logic [1:0]                batch_reg, batch_next;
    logic                      move;

    always_comb
    begin
        move     = (cnt_reg != 2'd0) && (!valid_reg || m_tready);
        can_load = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && move);

        buf_next = buf_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            buf_next = group.e;
            cnt_next = group.count;
        end
        else if (move)
        begin
            buf_next[0] = buf_reg[1];
            buf_next[1] = buf_reg[2];
            cnt_next    = cnt_reg - 2'd1;
        end

        valid_next = valid_reg;
        word_next  = word_reg;
        slot_next  = slot_reg;
        last_next  = last_reg;
        done_next  = done_reg;
        batch_next = batch_reg;
        if (move)
        begin
            valid_next = 1'b1;
            word_next  = seal(buf_reg[0].head) ^ {32{invert}};
            slot_next  = buf_reg[0].slot;
            last_next  = buf_reg[0].last;
            done_next  = buf_reg[0].done;
            batch_next = buf_reg[0].batches;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg   <= buf_next;
        word_reg  <= word_next;
        slot_reg  <= slot_next;
        last_reg  <= last_next;
        done_reg  <= done_next;
        batch_reg <= batch_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {3'b000, slot_reg, word_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = {batch_reg, done_reg};

endmodule

// ===== hw/rtl/pocsag_codeword_encoder_unit.sv =====
`timescale 1ns / 1ps
// Paging codeword encoder: characters in, sealed 32-bit codewords out.
// The first result of a word passes the result buffer and then the output register before it shows on m_tvalid.
// Throughput: one input word per cycle while each gives at most one result and the output is not stalled;
// a word giving more results (up to three) sends them one by one through the single output port.
// Reset (rst_n, async low) clears message state, buffers and config to defaults.
module pocsag_codeword_encoder_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // char_code[7:0]
    input  logic        s_tuser,    // has_char
    input  logic        s_tlast,    // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // codeword[31:0], slot_index[36:32], zero pad
    output logic        m_tlast,    // last_of_run
    output logic [2:0]  m_tuser,    // message_done[0], batch_count[2:1]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [20:0] cfg_data
);

    pcw_pkg::pcw_cfg_t   cfg;
    pcw_pkg::pcw_group_t group;
    logic                can_load;
    logic                accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = can_load;
    assign accept    = s_tvalid && can_load;

    pcw_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pcw_packer u_packer
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .char_code   (s_tdata),
        .has_char    (s_tuser),
        .end_of_text (s_tlast),
        .cfg         (cfg),
        .group       (group)
    );

    pcw_result_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .group    (group),
        .invert   (cfg.invert_output),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // end of message is always the last word of its run
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("message_done without last_of_run");

    // batch count only accompanies end of message
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tuser[2:1] == 2'd0)
        else $error("batch_count set on a non-final word");

    // a single batch means the final slot lies in the first batch
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] && m_tuser[2:1] == 2'd1 |-> !m_tdata[36])
        else $error("single batch with slot in second batch");

endmodule

// ===== dv/tb_pocsag_codeword_encoder_unit.sv =====
`timescale 1ns / 1ps
// Testbench for the paging codeword encoder: streams message characters, predicts every
// sealed codeword with a scoreboard class and checks the output stream word by word.
// Depends on hw/rtl/pcw_pkg.sv and hw/rtl/pocsag_codeword_encoder_unit.sv.
module tb_pocsag_codeword_encoder_unit;

    typedef struct {
        logic [31:0] codeword;
        logic [4:0]  slot;
        logic        last;
        logic        done;
        logic [1:0]  batches;
    } cw_result_t;

    class codeword_scoreboard;
        cw_result_t  expected_q[$];
        int          mismatches;
        int          checked;
        int          messages_done;

        // register copy
        logic [20:0] pager_address;
        logic [1:0]  function_bits;
        logic        invert;
        logic [1:0]  batch_mode;

        // message state
        logic [19:0] payload;
        int unsigned bit_count;
        logic [4:0]  slot;
        int unsigned chars_taken;
        bit          in_msg;

        // codewords raised by the current input word
        logic [31:0] run_word[4];
        logic [4:0]  run_slot[4];
        int          run_n;

        function new();
            pager_address = 21'd1;
            function_bits = 2'd0;
            invert        = 1'b0;
            batch_mode    = 2'd0;
            payload       = '0;
            bit_count     = 0;
            slot          = '0;
            chars_taken   = 0;
            in_msg        = 1'b0;
            mismatches    = 0;
            checked       = 0;
            messages_done = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [20:0] val);
            case (idx)
                pcw_pkg::CFG_PAGER_ADDRESS: pager_address = val;
                pcw_pkg::CFG_FUNCTION_BITS: function_bits = val[1:0];
                pcw_pkg::CFG_INVERT_OUTPUT: invert        = val[0];
                pcw_pkg::CFG_SECOND_BATCH:  batch_mode    = val[1:0];
                default: ;
            endcase
        endfunction

        // BCH(31,21) check bits at 10..1, even parity at bit 0
        function logic [31:0] seal(logic [31:0] data);
            logic [31:0] r;
            logic [31:0] w;
            r = data;
            for (int i = 0; i < 21; i++)
            begin
                if (r[31])
                    r = r ^ pcw_pkg::BCH_POLY;
                r = r << 1;
            end
            w = data | (r >> 21);
            if (^w)
                w[0] = 1'b1;
            return w;
        endfunction

        function void put_codeword(logic [31:0] data);
            if (run_n < 4)
            begin
                run_word[run_n] = seal(data);
                run_slot[run_n] = slot;
                run_n++;
            end
            slot = slot + 5'd1;
        endfunction

        function void flush_payload();
            logic [31:0] aligned;
            aligned = {12'b0, payload} << (20 - bit_count);
            put_codeword(32'h8000_0000 | ((aligned & 32'h000F_FFFF) << 11));
            payload   = '0;
            bit_count = 0;
        endfunction

        function void shift_char(logic [6:0] c);
            for (int b = 0; b < 7; b++)
            begin
                payload = {payload[18:0], c[b]};
                bit_count++;
                if (bit_count >= 20)
                    flush_payload();
            end
        endfunction

        function void note_input(logic [7:0] c, logic has, logic eot);
            logic [31:0] mask;
            logic [1:0]  batches;
            logic        lastk;
            cw_result_t  e;
            mask    = invert ? 32'hFFFF_FFFF : 32'h0;
            batches = 2'd0;
            run_n   = 0;
            if (!has && !eot)
                return;
            if (!in_msg)
            begin
                in_msg      = 1'b1;
                payload     = '0;
                bit_count   = 0;
                chars_taken = 0;
                slot        = {1'b0, pager_address[2:0], 1'b0};
                put_codeword({1'b0, pager_address[20:3], function_bits, 11'b0});
            end
            if (has && chars_taken < pcw_pkg::MAX_TEXT_CHARS)
            begin
                chars_taken++;
                shift_char(c[6:0]);
            end
            if (eot)
            begin
                shift_char(pcw_pkg::EOT_CHAR);
                if (bit_count > 0)
                    flush_payload();
                if (run_n > 0)
                    batches = (run_slot[run_n-1] < 5'd16
                               && batch_mode == pcw_pkg::BATCH_MODE_TRUNCATE) ? 2'd1 : 2'd2;
                in_msg      = 1'b0;
                payload     = '0;
                bit_count   = 0;
                chars_taken = 0;
                slot        = '0;
            end
            for (int k = 0; k < run_n && k < 3; k++)
            begin
                lastk      = (k == run_n - 1);
                e.codeword = run_word[k] ^ mask;
                e.slot     = run_slot[k];
                e.last     = lastk;
                e.done     = lastk && eot;
                e.batches  = e.done ? batches : 2'd0;
                expected_q.push_back(e);
            end
        endfunction

        function void check_result(logic [31:0] cw, logic [4:0] sl, logic last, logic done,
                                   logic [1:0] batches);
            cw_result_t e;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected codeword %h slot %0d last %b done %b batches %0d",
                             cw, sl, last, done, batches);
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (done)
                messages_done++;
            if (cw !== e.codeword || sl !== e.slot || last !== e.last || done !== e.done ||
                batches !== e.batches)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp %h/%0d/%b/%b/%0d got %h/%0d/%b/%b/%0d",
                             e.codeword, e.slot, e.last, e.done, e.batches,
                             cw, sl, last, done, batches);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic [2:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [20:0] cfg_data = '0;

    codeword_scoreboard sb;
    int send_idle = 23;
    int recv_idle = 59;
    int words_sent = 0;
    int msg_left = 0;

    pocsag_codeword_encoder_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d codewords still expected", sb.pending());
        $display("tb_pocsag_codeword_encoder_unit NOT OK");
        $finish;
    end

    // output side: check accepted words, then draw the next ready
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata[31:0], m_tdata[36:32], m_tlast, m_tuser[0], m_tuser[2:1]);
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic send_word(input logic [7:0] c, input logic has, input logic eot);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= has;
        s_tlast  <= eot;
        do @(posedge clk); while (!s_tready);
        sb.note_input(c, has, eot);
        words_sent++;
    endtask

    // words that raise nothing may still be in flight, so idle a little past the last result
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic set_config(input logic [20:0] addr, input logic [1:0] func,
                              input logic inv, input logic [1:0] mode);
        logic [20:0] vals[4];
        logic [1:0]  idx[4];
        vals[0] = addr;              idx[0] = pcw_pkg::CFG_PAGER_ADDRESS;
        vals[1] = {19'b0, func};     idx[1] = pcw_pkg::CFG_FUNCTION_BITS;
        vals[2] = {20'b0, inv};      idx[2] = pcw_pkg::CFG_INVERT_OUTPUT;
        vals[3] = {19'b0, mode};     idx[3] = pcw_pkg::CFG_SECOND_BATCH;
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            do @(posedge clk); while (!cfg_ready);
            sb.write_reg(idx[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // mostly real messages, some long enough to overflow the text limit, plus noise
    task automatic random_item(inout int n);
        int r;
        r = $urandom_range(99);
        if (r < 6)
            send_word(8'($urandom_range(255)), 1'b0, 1'b0);
        else if (r < 12)
        begin
            send_word(8'($urandom_range(255)), 1'b0, 1'b1);
            msg_left = 0;
            n++;
        end
        else
        begin
            if (msg_left == 0)
                msg_left = ($urandom_range(99) < 20) ? $urandom_range(45, 38)
                                                     : $urandom_range(8, 1);
            msg_left--;
            send_word(8'($urandom_range(255)), 1'b1,
                      (msg_left == 0 && $urandom_range(4) != 0));
            n++;
        end
    endtask

    initial
    begin
        int n;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset register values
        send_word(8'h41, 1'b0, 1'b1);          // empty message
        send_word(8'h00, 1'b0, 1'b0);          // idle word
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(8'h7F, 1'b1, 1'b0);
        send_word(8'h80, 1'b1, 1'b1);
        // 19 chars plus EOT fill seven codewords exactly
        for (int i = 0; i < 19; i++)
            send_word(8'($urandom_range(255)), 1'b1, (i == 18));
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase / 2)
                0:       begin send_idle = 23; recv_idle = 59; end
                1:       begin send_idle = 59; recv_idle = 23; end
                default: begin send_idle = 0;  recv_idle = 0;  end
            endcase
            case (phase)
                0: set_config(21'h1F_FFFF, 2'd3, 1'b1, 2'd3);
                1: set_config(21'h00_0000, 2'd0, 1'b0, 2'd1);
                2: set_config(21'($urandom_range(21'h1F_FFFF, 1)), 2'($urandom_range(3)),
                              1'b1, 2'd2);
                3: set_config(21'($urandom_range(21'h1F_FFFF, 1)), 2'($urandom_range(3)),
                              1'b0, 2'd0);
                default: set_config(21'($urandom_range(21'h1F_FFFF, 1)),
                                    2'($urandom_range(3)),
                                    1'($urandom_range(1)), 2'($urandom_range(3)));
            endcase
            n = 0;
            while (n < 22)
                random_item(n);
            drain();
        end

        $display("covered %0d input words, %0d codewords checked, %0d messages closed",
                 words_sent, sb.checked, sb.messages_done);
        $display("six register settings incl. extremes; idle 23/59, 59/23 and none; %0d mismatches",
                 sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb_pocsag_codeword_encoder_unit OK");
        else
            $display("tb_pocsag_codeword_encoder_unit NOT OK");
        $finish;
    end

endmodule
